@@ rtl/dgc_pkg.sv @@
// Shared constants, item types and sequencer codes for the dependency graph cull block.
`default_nettype none

package dgc_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 256;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int EDGE_AW    = $clog2(MAX_EDGES);
    localparam int NODE_CNT_W = NODE_W + 1;
    localparam int EDGE_CNT_W = EDGE_AW + 1;
    localparam int CNT_W      = EDGE_CNT_W;
    localparam int EDGE_W     = 2 * NODE_W;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_NODE = 2'd0;
    localparam t_mode MODE_EDGE = 2'd1;
    localparam t_mode MODE_CULL = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_NODE_OVF = 3'd1;
    localparam t_status ST_EDGE_OVF = 3'd2;
    localparam t_status ST_UNKNOWN  = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

    typedef struct packed {
        t_mode             mode;
        logic              side_effect;
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
    } t_in_item;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic              culled;
        t_status           status;
        logic              last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EINC_RD,
        S_EINC_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP,
        S_POP_WAIT,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_DEC,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    typedef enum logic {
        ALU_INC,
        ALU_DEC
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [CNT_W-1:0] operand;
    } t_alu_req;

    typedef struct packed {
        logic [CNT_W-1:0] value;
        logic             zero;
    } t_alu_rsp;

endpackage

`default_nettype wire

@@ rtl/dependency_graph_cull.sv @@
// Top level: dependency graph loader and reference count cull sequencer.
// Node declare keeps the block idle; edge declare runs S_EINC_RD then S_EINC_WR.
// Empty cull: result the cycle after. Cull: scan, edge walk per popped node, emit.
// Results come one per node in id order (S_EMIT_RD, S_EMIT); the receiver cannot stall.
// The edge store walk per popped node (one edge RAM read port) sets the cull time.
// Sync reset clears the sequencer, totals and error; RAMs keep contents, no clearing pass.
`default_nettype none

module dependency_graph_cull (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire dgc_pkg::t_in_item  i_item,
    output logic                    o_valid,
    output dgc_pkg::t_out_item      o_result
);

    localparam int NW  = dgc_pkg::NODE_W;
    localparam int NCW = dgc_pkg::NODE_CNT_W;
    localparam int EAW = dgc_pkg::EDGE_AW;
    localparam int ECW = dgc_pkg::EDGE_CNT_W;
    localparam int CW  = dgc_pkg::CNT_W;
    localparam int EW  = dgc_pkg::EDGE_W;

    // Sequencer and load state.
    dgc_pkg::t_state    r_state, n_state;
    logic [NCW-1:0]     r_node_total, n_node_total;
    logic [ECW-1:0]     r_edge_total, n_edge_total;
    dgc_pkg::t_status   r_error, n_error;
    logic [NCW-1:0]     r_sp, n_sp;
    // Walk pointers and captured ids.
    logic [NW-1:0]      r_idx, n_idx;
    logic [EAW-1:0]     r_eidx, n_eidx;
    logic [NW-1:0]      r_from, n_from;
    logic [NW-1:0]      r_node, n_node;
    // Result register.
    logic               r_valid, n_valid;
    dgc_pkg::t_out_item r_result, n_result;

    // RAM ports.
    logic              side_we, ref_we, edge_we, stack_we;
    logic [NW-1:0]     side_waddr, ref_waddr, node_raddr, stack_waddr, stack_raddr;
    logic              side_wdata, side_rdata;
    logic [CW-1:0]     ref_wdata, ref_rdata;
    logic [EAW-1:0]    edge_waddr, edge_raddr;
    logic [EW-1:0]     edge_wdata, edge_rdata;
    logic [NW-1:0]     stack_wdata, stack_rdata;

    dgc_pkg::t_alu_req alu_req;
    dgc_pkg::t_alu_rsp alu_rsp;

    logic              accept;
    logic              node_full, edge_full, unknown_node;
    logic              idx_last, eidx_last, stack_room;
    logic [NCW-1:0]    sp_dec;
    logic [NW-1:0]     rd_from, rd_to;

    assign accept       = start && !busy;
    assign busy         = (r_state != dgc_pkg::S_IDLE);
    assign node_full    = (r_node_total >= NCW'(dgc_pkg::MAX_NODES));
    assign edge_full    = (r_edge_total >= ECW'(dgc_pkg::MAX_EDGES));
    assign unknown_node = ({1'b0, i_item.edge_from} >= r_node_total)
                       || ({1'b0, i_item.edge_to} >= r_node_total);
    assign idx_last     = (NCW'(r_idx) + 1'b1) == r_node_total;
    assign eidx_last    = (ECW'(r_eidx) + 1'b1) == r_edge_total;
    assign stack_room   = (r_sp < NCW'(dgc_pkg::MAX_NODES));
    assign sp_dec       = r_sp - 1'b1;
    assign rd_from      = edge_rdata[EW-1:NW];
    assign rd_to        = edge_rdata[NW-1:0];

    // Side marks and counts share one read address.
    dgc_ram #(.WIDTH(1), .DEPTH(dgc_pkg::MAX_NODES)) u_side_ram (
        .i_clk   (i_clk),
        .i_we    (side_we),
        .i_waddr (side_waddr),
        .i_wdata (side_wdata),
        .i_raddr (node_raddr),
        .o_rdata (side_rdata)
    );

    dgc_ram #(.WIDTH(CW), .DEPTH(dgc_pkg::MAX_NODES)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (ref_wdata),
        .i_raddr (node_raddr),
        .o_rdata (ref_rdata)
    );

    dgc_ram #(.WIDTH(EW), .DEPTH(dgc_pkg::MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    dgc_ram #(.WIDTH(NW), .DEPTH(dgc_pkg::MAX_NODES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (stack_waddr),
        .i_wdata (stack_wdata),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

    // One count unit serves both the load-time increment and the cull decrement.
    dgc_count_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dgc_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.mode)
                        dgc_pkg::MODE_EDGE: begin
                            if (!edge_full && !unknown_node) begin
                                n_state = dgc_pkg::S_EINC_RD;
                            end
                        end
                        dgc_pkg::MODE_CULL: begin
                            if (r_node_total != '0) begin
                                n_state = dgc_pkg::S_SCAN_RD;
                            end
                        end
                        default: n_state = dgc_pkg::S_IDLE;
                    endcase
                end
            end
            dgc_pkg::S_EINC_RD:  n_state = dgc_pkg::S_EINC_WR;
            dgc_pkg::S_EINC_WR:  n_state = dgc_pkg::S_IDLE;
            dgc_pkg::S_SCAN_RD:  n_state = dgc_pkg::S_SCAN_CHK;
            dgc_pkg::S_SCAN_CHK: n_state = idx_last ? dgc_pkg::S_POP : dgc_pkg::S_SCAN_RD;
            dgc_pkg::S_POP: begin
                n_state = (r_sp == '0) ? dgc_pkg::S_EMIT_RD : dgc_pkg::S_POP_WAIT;
            end
            dgc_pkg::S_POP_WAIT: begin
                n_state = (r_edge_total == '0) ? dgc_pkg::S_POP : dgc_pkg::S_EDGE_RD;
            end
            dgc_pkg::S_EDGE_RD:  n_state = dgc_pkg::S_EDGE_CHK;
            dgc_pkg::S_EDGE_CHK: begin
                if (rd_to == r_node) begin
                    n_state = dgc_pkg::S_DEC;
                end else begin
                    n_state = eidx_last ? dgc_pkg::S_POP : dgc_pkg::S_EDGE_RD;
                end
            end
            dgc_pkg::S_DEC:      n_state = eidx_last ? dgc_pkg::S_POP : dgc_pkg::S_EDGE_RD;
            dgc_pkg::S_EMIT_RD:  n_state = dgc_pkg::S_EMIT;
            dgc_pkg::S_EMIT:     n_state = idx_last ? dgc_pkg::S_IDLE : dgc_pkg::S_EMIT_RD;
            default:             n_state = dgc_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and register next values.
    always_comb begin
        n_node_total = r_node_total;
        n_edge_total = r_edge_total;
        n_error      = r_error;
        n_sp         = r_sp;
        n_idx        = r_idx;
        n_eidx       = r_eidx;
        n_from       = r_from;
        n_node       = r_node;
        n_valid      = 1'b0;
        n_result     = r_result;

        side_we      = 1'b0;
        side_waddr   = r_node_total[NW-1:0];
        side_wdata   = i_item.side_effect;
        ref_we       = 1'b0;
        ref_waddr    = r_from;
        ref_wdata    = alu_rsp.value;
        node_raddr   = r_idx;
        edge_we      = 1'b0;
        edge_waddr   = r_edge_total[EAW-1:0];
        edge_wdata   = {i_item.edge_from, i_item.edge_to};
        edge_raddr   = r_eidx;
        stack_we     = 1'b0;
        stack_waddr  = r_sp[NW-1:0];
        stack_wdata  = r_idx;
        stack_raddr  = sp_dec[NW-1:0];
        alu_req.op      = dgc_pkg::ALU_INC;
        alu_req.operand = ref_rdata;

        case (r_state)
            dgc_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.mode)
                        dgc_pkg::MODE_NODE: begin
                            if (node_full) begin
                                if (r_error == dgc_pkg::ST_OK) begin
                                    n_error = dgc_pkg::ST_NODE_OVF;
                                end
                            end else begin
                                // Declare the node: store its side-effect flag and zero its count.
                                side_we      = 1'b1;
                                ref_we       = 1'b1;
                                ref_waddr    = r_node_total[NW-1:0];
                                ref_wdata    = '0;
                                n_node_total = r_node_total + 1'b1;
                            end
                        end
                        dgc_pkg::MODE_EDGE: begin
                            if (edge_full) begin
                                if (r_error == dgc_pkg::ST_OK) begin
                                    n_error = dgc_pkg::ST_EDGE_OVF;
                                end
                            end else if (unknown_node) begin
                                if (r_error == dgc_pkg::ST_OK) begin
                                    n_error = dgc_pkg::ST_UNKNOWN;
                                end
                            end else begin
                                edge_we      = 1'b1;
                                n_edge_total = r_edge_total + 1'b1;
                                n_from       = i_item.edge_from;
                            end
                        end
                        dgc_pkg::MODE_CULL: begin
                            if (r_node_total == '0) begin
                                n_valid          = 1'b1;
                                n_result.node_id = '0;
                                n_result.culled  = 1'b0;
                                n_result.status  = (r_error != dgc_pkg::ST_OK) ?
                                                   r_error : dgc_pkg::ST_EMPTY;
                                n_result.last    = 1'b1;
                                n_node_total     = '0;
                                n_edge_total     = '0;
                                n_error          = dgc_pkg::ST_OK;
                            end else begin
                                n_idx = '0;
                                n_sp  = '0;
                            end
                        end
                        default: n_valid = 1'b0;
                    endcase
                end
            end
            dgc_pkg::S_EINC_RD: begin
                node_raddr = r_from;
            end
            dgc_pkg::S_EINC_WR: begin
                alu_req.op = dgc_pkg::ALU_INC;
                ref_we     = 1'b1;
            end
            dgc_pkg::S_SCAN_RD: begin
                node_raddr = r_idx;
            end
            dgc_pkg::S_SCAN_CHK: begin
                if (!side_rdata && ref_rdata == '0 && stack_room) begin
                    stack_we = 1'b1;
                    n_sp     = r_sp + 1'b1;
                end
                if (!idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            dgc_pkg::S_POP: begin
                if (r_sp != '0) begin
                    n_sp = sp_dec;
                end else begin
                    n_idx = '0;
                end
            end
            dgc_pkg::S_POP_WAIT: begin
                n_node = stack_rdata;
                n_eidx = '0;
            end
            dgc_pkg::S_EDGE_RD: begin
                edge_raddr = r_eidx;
            end
            dgc_pkg::S_EDGE_CHK: begin
                if (rd_to == r_node) begin
                    node_raddr = rd_from;
                    n_from     = rd_from;
                end else if (!eidx_last) begin
                    n_eidx = r_eidx + 1'b1;
                end
            end
            dgc_pkg::S_DEC: begin
                // Drop one reference from a writer without side effects; push it when none remain.
                alu_req.op = dgc_pkg::ALU_DEC;
                if (!side_rdata && ref_rdata != '0) begin
                    ref_we = 1'b1;
                    if (alu_rsp.zero && stack_room) begin
                        stack_we    = 1'b1;
                        stack_wdata = r_from;
                        n_sp        = r_sp + 1'b1;
                    end
                end
                if (!eidx_last) begin
                    n_eidx = r_eidx + 1'b1;
                end
            end
            dgc_pkg::S_EMIT_RD: begin
                node_raddr = r_idx;
            end
            dgc_pkg::S_EMIT: begin
                n_valid          = 1'b1;
                n_result.node_id = r_idx;
                n_result.culled  = !side_rdata && (ref_rdata == '0);
                n_result.status  = r_error;
                n_result.last    = idx_last;
                if (idx_last) begin
                    n_node_total = '0;
                    n_edge_total = '0;
                    n_error      = dgc_pkg::ST_OK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dgc_pkg::S_IDLE;
            r_node_total <= '0;
            r_edge_total <= '0;
            r_error      <= dgc_pkg::ST_OK;
            r_sp         <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_total <= n_node_total;
            r_edge_total <= n_edge_total;
            r_error      <= n_error;
            r_sp         <= n_sp;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_eidx   <= n_eidx;
        r_from   <= n_from;
        r_node   <= n_node;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

@@ rtl/dgc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/dgc_count_alu.sv @@
// Shared reference count unit: increment or decrement with zero detect.
`default_nettype none

module dgc_count_alu (
    input  wire dgc_pkg::t_alu_req i_req,
    output dgc_pkg::t_alu_rsp      o_rsp
);

    logic [dgc_pkg::CNT_W-1:0] value;

    always_comb begin
        case (i_req.op)
            dgc_pkg::ALU_INC: value = i_req.operand + 1'b1;
            dgc_pkg::ALU_DEC: value = i_req.operand - 1'b1;
            default:          value = i_req.operand;
        endcase
    end

    assign o_rsp.value = value;
    assign o_rsp.zero  = (value == '0);

endmodule

`default_nettype wire

@@ rtl/dgc_checker.sv @@
// Port-level checker for the dependency graph cull block, with its bind.
`default_nettype none

module dgc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire dgc_pkg::t_in_item  i_item,
    input wire logic               o_valid,
    input wire dgc_pkg::t_out_item o_result
);

    logic accept;
    assign accept = start && !busy;

    a_node_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.mode == dgc_pkg::MODE_NODE |=> !busy && !o_valid)
        else $error("node declare left the block busy or produced a result");

    a_edge_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.mode == dgc_pkg::MODE_EDGE |=> !o_valid)
        else $error("edge declare produced a result");

    a_cull_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_item.mode == dgc_pkg::MODE_CULL |=> busy || (o_valid && o_result.last))
        else $error("cull neither started nor returned the empty result");

    a_more_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last |-> busy)
        else $error("run went idle before its last result");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.status == dgc_pkg::ST_EMPTY |->
            o_result.last && !o_result.culled && o_result.node_id == '0)
        else $error("empty status on a result that is not the lone empty result");

endmodule

bind dependency_graph_cull dgc_checker u_dgc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
